>>> sv/estm_pkg.sv
// Package for the Euler scale/translate matrix unit: item types, CORDIC constants.
// Used by every module of the block.
`timescale 1ns / 1ps
package estm_pkg;

  typedef struct packed {
    logic signed [15:0] rot_x_deg;
    logic signed [15:0] rot_y_deg;
    logic signed [15:0] rot_z_deg;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         column;
    logic signed [31:0] row0_value;
    logic signed [31:0] row1_value;
    logic signed [31:0] row2_value;
    logic signed [31:0] row3_value;
    logic               last;
  } out_item_t;

  // One queued matrix job: sine/cosine of each axis plus scale and position.
  typedef struct packed {
    logic signed [15:0] sx, cx, sy, cy, sz, cz;
    logic signed [31:0] scale_x, scale_y, scale_z;
    logic signed [31:0] pos_x, pos_y, pos_z;
  } job_t;

  localparam int AtanSize = 24;
  localparam logic signed [19:0] FullTurn    = 20'sd23040;
  localparam logic signed [19:0] HalfTurn    = 20'sd11520;
  localparam logic signed [19:0] QuarterTurn = 20'sd5760;
  localparam logic signed [17:0] CordicGain  = 18'sd19898;
  localparam logic signed [31:0] OneQ16      = 32'sd65536;

  function automatic logic signed [23:0] atan_deg16(input logic [4:0] i);
    case (i)
      5'd0: atan_deg16 = 24'sd2949120;  5'd1: atan_deg16 = 24'sd1740967;
      5'd2: atan_deg16 = 24'sd919879;   5'd3: atan_deg16 = 24'sd466945;
      5'd4: atan_deg16 = 24'sd234379;   5'd5: atan_deg16 = 24'sd117304;
      5'd6: atan_deg16 = 24'sd58666;    5'd7: atan_deg16 = 24'sd29335;
      5'd8: atan_deg16 = 24'sd14668;    5'd9: atan_deg16 = 24'sd7334;
      5'd10: atan_deg16 = 24'sd3667;    5'd11: atan_deg16 = 24'sd1833;
      5'd12: atan_deg16 = 24'sd917;     5'd13: atan_deg16 = 24'sd458;
      5'd14: atan_deg16 = 24'sd229;     5'd15: atan_deg16 = 24'sd115;
      5'd16: atan_deg16 = 24'sd57;      5'd17: atan_deg16 = 24'sd29;
      5'd18: atan_deg16 = 24'sd14;      5'd19: atan_deg16 = 24'sd7;
      5'd20: atan_deg16 = 24'sd4;       5'd21: atan_deg16 = 24'sd2;
      5'd22: atan_deg16 = 24'sd1;
      default: atan_deg16 = 24'sd0;
    endcase
  endfunction

  // Q1.15 product rounded back to Q1.15 (operands fit 18 bits).
  function automatic logic signed [17:0] rmul15(input logic signed [17:0] a,
                                                input logic signed [17:0] b);
    logic signed [35:0] p;
    p = a * b + 36'sd16384;
    rmul15 = p[32:15];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v > 50'sh7FFFFFFF) sat32 = 32'sh7FFFFFFF;
    else if (v < -50'sh80000000) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction

endpackage

>>> sv/estm_cordic.sv
// Pipelined rotation-mode CORDIC for one angle, folded to +-90 degrees first.
// Depends on estm_pkg.
`timescale 1ns / 1ps
module estm_cordic import estm_pkg::*; #(
  parameter int STEPS = 16
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] ang,
  output logic signed [15:0] sin_o,
  output logic signed [15:0] cos_o
);
  localparam int N = (STEPS > AtanSize) ? AtanSize : STEPS;

  logic signed [19:0] red_r;
  logic               neg_r;
  logic signed [19:0] r0, r1;
  logic signed [17:0] x_r [0:N];
  logic signed [17:0] y_r [0:N];
  logic signed [24:0] z_r [0:N];
  logic               ng_r [0:N];
  logic signed [17:0] xc, yc;

  // ang lies in [-512,512) degrees: fold by at most two turns
  always_comb begin
    r0 = 20'(ang);
    if (r0 >= HalfTurn) r0 = r0 - FullTurn;
    if (r0 >= HalfTurn) r0 = r0 - FullTurn;
    if (r0 < -HalfTurn) r0 = r0 + FullTurn;
    if (r0 < -HalfTurn) r0 = r0 + FullTurn;
    r1 = r0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (r1 > QuarterTurn) begin
        red_r <= r1 - HalfTurn; neg_r <= 1'b1;
      end else if (r1 < -QuarterTurn) begin
        red_r <= r1 + HalfTurn; neg_r <= 1'b1;
      end else begin
        red_r <= r1; neg_r <= 1'b0;
      end
    end
  end

  always_comb begin
    x_r[0]  = CordicGain;
    y_r[0]  = '0;
    z_r[0]  = 25'(red_r) <<< 10;
    ng_r[0] = neg_r;
  end

  for (genvar i = 0; i < N; i++) begin : g_st
    always_ff @(posedge clk) begin
      if (en) begin
        ng_r[i+1] <= ng_r[i];
        if (!z_r[i][24]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - 25'(atan_deg16(5'(i)));
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + 25'(atan_deg16(5'(i)));
        end
      end
    end
  end

  always_comb begin
    xc = ng_r[N] ? -x_r[N] : x_r[N];
    yc = ng_r[N] ? -y_r[N] : y_r[N];
    if (xc > 18'sd32767) cos_o = 16'sd32767;
    else if (xc < -18'sd32767) cos_o = -16'sd32767;
    else cos_o = xc[15:0];
    if (yc > 18'sd32767) sin_o = 16'sd32767;
    else if (yc < -18'sd32767) sin_o = -16'sd32767;
    else sin_o = yc[15:0];
  end
endmodule

>>> sv/estm_front.sv
// Front end: accepts items, runs three CORDIC pipelines, pushes jobs to the queue.
// Depends on estm_pkg and estm_cordic.
`timescale 1ns / 1ps
module estm_front import estm_pkg::*; #(
  parameter int STEPS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     take,
  input  in_item_t item,
  output logic     push,
  output job_t     job
);
  localparam int N   = (STEPS > AtanSize) ? AtanSize : STEPS;
  localparam int LAT = N + 1;

  logic [LAT-1:0] vld_r;
  in_item_t       pay_r [0:LAT-1];
  logic signed [15:0] sx, cx, sy, cy, sz, cz;

  estm_cordic #(.STEPS(STEPS)) u_cx (.clk, .en(1'b1), .ang(item.rot_x_deg),
                                     .sin_o(sx), .cos_o(cx));
  estm_cordic #(.STEPS(STEPS)) u_cy (.clk, .en(1'b1), .ang(item.rot_y_deg),
                                     .sin_o(sy), .cos_o(cy));
  estm_cordic #(.STEPS(STEPS)) u_cz (.clk, .en(1'b1), .ang(item.rot_z_deg),
                                     .sin_o(sz), .cos_o(cz));

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= {vld_r[LAT-2:0], take};
  end

  always_ff @(posedge clk) begin
    pay_r[0] <= item;
    for (int i = 1; i < LAT; i++) pay_r[i] <= pay_r[i-1];
  end

  assign push = vld_r[LAT-1];
  always_comb begin
    job.sx = sx; job.cx = cx; job.sy = sy; job.cy = cy; job.sz = sz; job.cz = cz;
    job.scale_x = pay_r[LAT-1].scale_x;
    job.scale_y = pay_r[LAT-1].scale_y;
    job.scale_z = pay_r[LAT-1].scale_z;
    job.pos_x = pay_r[LAT-1].pos_x;
    job.pos_y = pay_r[LAT-1].pos_y;
    job.pos_z = pay_r[LAT-1].pos_z;
  end
endmodule

>>> sv/estm_back.sv
// Back end: job queue, rotation products, scaling, one column per cycle.
// Depends on estm_pkg.
`timescale 1ns / 1ps
module estm_back import estm_pkg::*; #(
  parameter int QDEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  job_t      job,
  output logic      full,
  output logic      out_v,
  output out_item_t out_item
);
  localparam int QW = $clog2(QDEPTH);

  job_t          q_r [0:QDEPTH-1];
  logic [QW-1:0] wp_r, rp_r;
  logic [QW:0]   cnt_r, cnt_nxt;
  logic          pop;

  // product stages
  logic          v1_r, v2_r, v3_r;
  logic [1:0]    c1_r, c2_r, c3_r, col4_r;
  job_t          j1_r;
  logic signed [17:0] sxsy_r, cxsy_r, p_r [0:8];
  logic signed [17:0] e_r [0:2];
  logic signed [31:0] s2_r, s3_r, pos_r [0:2], pos3_r [0:2], pos4_r [0:2];
  logic signed [49:0] m_r [0:2];
  logic [1:0]    col_r;
  logic          busy_r;

  // pop a job when the queue holds one and the back end is idle or on column 3; its columns 0..3 follow in order
  assign pop = (cnt_r != '0) && (!busy_r || col_r == 2'd3);
  assign cnt_nxt = cnt_r + (QW+1)'(push) - (QW+1)'(pop);
  // full is tied low: the accept spacing at the top level keeps the queue from filling
  assign full = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0; busy_r <= 1'b0; col_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      if (pop) begin
        busy_r <= 1'b1; col_r <= 2'd0;
      end else if (busy_r) begin
        col_r <= col_r + 1'b1;
        if (col_r == 2'd3) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) if (push) q_r[wp_r] <= job;

  // stage 1: latch job, advance per column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; out_v <= 1'b0;
    end else begin
      v1_r <= pop || (busy_r && col_r != 2'd3);
      v2_r <= v1_r; v3_r <= v2_r; out_v <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      j1_r <= q_r[rp_r]; c1_r <= 2'd0;
    end else c1_r <= c1_r + 1'b1;
    // stage 2: pairwise products
    sxsy_r <= rmul15(18'(j1_r.sx), 18'(j1_r.sy));
    cxsy_r <= rmul15(18'(j1_r.cx), 18'(j1_r.sy));
    p_r[0] <= rmul15(18'(j1_r.cy), 18'(j1_r.cz));
    p_r[1] <= rmul15(18'(j1_r.cx), 18'(j1_r.sz));
    p_r[2] <= rmul15(18'(j1_r.sx), 18'(j1_r.sz));
    p_r[3] <= rmul15(18'(j1_r.cy), 18'(j1_r.sz));
    p_r[4] <= rmul15(18'(j1_r.cx), 18'(j1_r.cz));
    p_r[5] <= rmul15(18'(j1_r.sx), 18'(j1_r.cz));
    p_r[6] <= 18'(j1_r.sy);
    p_r[7] <= rmul15(18'(j1_r.sx), 18'(j1_r.cy));
    p_r[8] <= rmul15(18'(j1_r.cx), 18'(j1_r.cy));
    s2_r <= (c1_r == 2'd0) ? j1_r.scale_x : (c1_r == 2'd1) ? j1_r.scale_y : j1_r.scale_z;
    pos_r[0] <= j1_r.pos_x; pos_r[1] <= j1_r.pos_y; pos_r[2] <= j1_r.pos_z;
    c2_r <= c1_r;
    // stage 3: triple products and column select
    case (c2_r)
      2'd0: begin
        e_r[0] <= p_r[0];
        e_r[1] <= p_r[1] + rmul15(sxsy_r, 18'(j1_r.cz));
        e_r[2] <= p_r[2] - rmul15(cxsy_r, 18'(j1_r.cz));
      end
      2'd1: begin
        e_r[0] <= -p_r[3];
        e_r[1] <= p_r[4] - rmul15(sxsy_r, 18'(j1_r.sz));
        e_r[2] <= p_r[5] + rmul15(cxsy_r, 18'(j1_r.sz));
      end
      default: begin
        e_r[0] <= p_r[6]; e_r[1] <= -p_r[7]; e_r[2] <= p_r[8];
      end
    endcase
    s3_r <= s2_r; c3_r <= c2_r;
    for (int k = 0; k < 3; k++) pos3_r[k] <= pos_r[k];
    // stage 4: scale
    for (int k = 0; k < 3; k++) begin
      m_r[k] <= 50'(e_r[k]) * 50'(s3_r) + 50'sd16384;
      pos4_r[k] <= pos3_r[k];
    end
    col4_r <= c3_r;
  end

  always_comb begin
    out_item.column     = col4_r;
    out_item.last       = (col4_r == 2'd3);
    out_item.row0_value = (col4_r == 2'd3) ? pos4_r[0] : sat32(m_r[0] >>> 15);
    out_item.row1_value = (col4_r == 2'd3) ? pos4_r[1] : sat32(m_r[1] >>> 15);
    out_item.row2_value = (col4_r == 2'd3) ? pos4_r[2] : sat32(m_r[2] >>> 15);
    out_item.row3_value = (col4_r == 2'd3) ? OneQ16 : 32'sd0;
  end
endmodule

>>> sv/euler_scale_translate_matrix_unit.sv
// Top level of the Euler scale/translate matrix unit.
// Depends on estm_pkg, estm_front, estm_back.
`timescale 1ns / 1ps
// An item is taken when start is high and busy low; busy then stays high while
// the gap counter gap_r runs down, so items are spaced apart, and a new item can
// be taken while earlier ones are still in the pipeline. Its four columns leave
// on out_valid, one per cycle in order 0..3, paced by the single-column back
// end; the receiver cannot stall.
module euler_scale_translate_matrix_unit import estm_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);
  logic [1:0] gap_r;
  logic       take, push, full;
  job_t       job;

  assign busy = (gap_r != 2'd0) || full;
  assign take = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) gap_r <= '0;
    else if (take) gap_r <= 2'd3;
    else if (gap_r != 2'd0) gap_r <= gap_r - 1'b1;
  end

  estm_front #(.STEPS(CORDIC_STEPS)) u_front (
    .clk, .rst_n, .take, .item(in_item), .push, .job);

  estm_back #(.QDEPTH(4)) u_back (
    .clk, .rst_n, .push, .job, .full, .out_v(out_valid), .out_item);
endmodule

>>> sv/estm_checker.sv
// Port-level checker for the matrix unit, bound to the top level.
// Depends on estm_pkg.
`timescale 1ns / 1ps
module estm_checker import estm_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_item
);
  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accept spacing");
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.column != 2'd3 |=> out_valid &&
      out_item.column == $past(out_item.column) + 2'd1) else $error("column order");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.last == (out_item.column == 2'd3)) else $error("last mark");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.column == 2'd3 |-> out_item.row3_value == OneQ16)
    else $error("row3");
endmodule

bind euler_scale_translate_matrix_unit estm_checker u_chk (
  .clk, .rst_n, .start, .busy, .out_valid, .out_item);

>>> tb/sv/estm_matrix_checker.sv
// Checker for the Euler scale/translate matrix unit: watches accepted items,
// computes the four expected matrix columns per item and compares results.
// Depends on estm_pkg.
`timescale 1ns / 1ps
module estm_matrix_checker import estm_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  out_item_t out_item,
  output int        fail_count,
  output int        pending_columns
);

  localparam int TurnFull = 23040;
  localparam int TurnHalf = 11520;
  localparam int TurnQuarter = 5760;
  localparam int GainQ15 = 19898;
  localparam int UnitQ16 = 65536;

  int arctan_deg16 [24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                            29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                            57, 29, 14, 7, 4, 2, 1, 0};

  out_item_t expected_columns[$];

  assign pending_columns = expected_columns.size();

  function automatic int clamp_unit(int v);
    if (v > 32767) return 32767;
    if (v < -32767) return -32767;
    return v;
  endfunction

  function automatic int round_q15(longint a, longint b);
    longint p;
    p = a * b + 16384;
    return int'(p >>> 15);
  endfunction

  function automatic logic [31:0] scaled_entry(int q15, longint scale);
    longint r;
    r = (longint'(q15) * scale + 16384) >>> 15;
    if (r > 64'sh7FFFFFFF) r = 64'sh7FFFFFFF;
    if (r < -64'sh80000000) r = -64'sh80000000;
    return r[31:0];
  endfunction

  task automatic angle_sin_cos(input logic signed [15:0] ang, output int s, output int c);
    int r, x, y, z, dx, dy, n;
    bit flip;
    r = int'(ang) % TurnFull;
    flip = 0;
    if (r < 0) r += TurnFull;
    if (r >= TurnHalf) r -= TurnFull;
    if (r > TurnQuarter) begin
      r -= TurnHalf;
      flip = 1;
    end else if (r < -TurnQuarter) begin
      r += TurnHalf;
      flip = 1;
    end
    z = r * 1024;
    x = GainQ15;
    y = 0;
    n = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    for (int i = 0; i < n; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_deg16[i];
      end else begin
        x += dx; y -= dy; z += arctan_deg16[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = clamp_unit(x);
    s = clamp_unit(y);
  endtask

  task automatic predict_matrix(input in_item_t it);
    int sx, cx, sy, cy, sz, cz, sxsy, cxsy;
    int e[3][3];
    longint scale[3];
    out_item_t col;
    angle_sin_cos(it.rot_x_deg, sx, cx);
    angle_sin_cos(it.rot_y_deg, sy, cy);
    angle_sin_cos(it.rot_z_deg, sz, cz);
    scale[0] = it.scale_x;
    scale[1] = it.scale_y;
    scale[2] = it.scale_z;
    sxsy = round_q15(sx, sy);
    cxsy = round_q15(cx, sy);
    e[0][0] = round_q15(cy, cz);
    e[0][1] = round_q15(cx, sz) + round_q15(sxsy, cz);
    e[0][2] = round_q15(sx, sz) - round_q15(cxsy, cz);
    e[1][0] = -round_q15(cy, sz);
    e[1][1] = round_q15(cx, cz) - round_q15(sxsy, sz);
    e[1][2] = round_q15(sx, cz) + round_q15(cxsy, sz);
    e[2][0] = sy;
    e[2][1] = -round_q15(sx, cy);
    e[2][2] = round_q15(cx, cy);
    for (int k = 0; k < 3; k++) begin
      col.column = k[1:0];
      col.row0_value = scaled_entry(e[k][0], scale[k]);
      col.row1_value = scaled_entry(e[k][1], scale[k]);
      col.row2_value = scaled_entry(e[k][2], scale[k]);
      col.row3_value = '0;
      col.last = 1'b0;
      expected_columns = {expected_columns, col};
    end
    col.column = 2'd3;
    col.row0_value = it.pos_x;
    col.row1_value = it.pos_y;
    col.row2_value = it.pos_z;
    col.row3_value = UnitQ16;
    col.last = 1'b1;
    expected_columns = {expected_columns, col};
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && start && !busy) predict_matrix(in_item);
    if (rst_n && out_valid) begin
      if (expected_columns.size() == 0) begin
        report_mismatch("unexpected column", 32'(out_item.column), 32'd0);
      end else begin
        want = expected_columns.pop_front();
        if (out_item.column !== want.column)
          report_mismatch("column", 32'(out_item.column), 32'(want.column));
        if (out_item.row0_value !== want.row0_value)
          report_mismatch("row0", out_item.row0_value, want.row0_value);
        if (out_item.row1_value !== want.row1_value)
          report_mismatch("row1", out_item.row1_value, want.row1_value);
        if (out_item.row2_value !== want.row2_value)
          report_mismatch("row2", out_item.row2_value, want.row2_value);
        if (out_item.row3_value !== want.row3_value)
          report_mismatch("row3", out_item.row3_value, want.row3_value);
        if (out_item.last !== want.last)
          report_mismatch("last", 32'(out_item.last), 32'(want.last));
      end
    end
  end

endmodule

>>> tb/sv/tb_euler_scale_translate_matrix_unit.sv
// Testbench top for the Euler scale/translate matrix unit: drives directed and
// random items, idles in bursts, and gives the verdict from the checker.
// Depends on estm_pkg, euler_scale_translate_matrix_unit, estm_matrix_checker.
`timescale 1ns / 1ps
module tb_euler_scale_translate_matrix_unit;
  import estm_pkg::*;

  localparam int Steps = 16;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_item;
  int        fail_count;
  int        pending_columns;

  euler_scale_translate_matrix_unit #(.CORDIC_STEPS(Steps)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item)
  );

  estm_matrix_checker #(.CORDIC_STEPS(Steps)) checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .fail_count(fail_count),
    .pending_columns(pending_columns)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(0, 32'h3FFFF) - 32'h1FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return 16'(($urandom_range(0, 8) - 4) * 5760);
      1: return 16'($urandom_range(0, 11520) - 5760);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_matrix(input in_item_t it, input bit allow_idle);
    int gap;
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_directed(input logic [15:0] rx, ry, rz,
                               input logic [31:0] sx, sy, sz, px, py, pz);
    in_item_t it;
    it = {rx, ry, rz, sx, sy, sz, px, py, pz};
    send_matrix(it, 1'b1);
  endtask

  initial begin
    in_item_t it;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_directed(16'd0, 16'd0, 16'd0, 32'h10000, 32'h10000, 32'h10000, 0, 0, 0);
    send_directed(16'sd5760, 16'sd5760, 16'sd5760, 32'h10000, 32'h20000, 32'h30000,
                  32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF);
    send_directed(-16'sd5760, -16'sd5760, -16'sd5760, 32'hFFFF0000, 32'h10000,
                  32'h8000, 32'h1, 32'h2, 32'h3);
    send_directed(16'sd11520, -16'sd11520, 16'sd17280, 32'h10000, 32'h10000,
                  32'h10000, 0, 0, 0);
    send_directed(16'h7FFF, 16'h8000, 16'sd23040, 32'h7FFFFFFF, 32'h80000000,
                  32'h7FFFFFFF, 32'h55555555, 32'hAAAAAAAA, 32'h0);
    send_directed(16'h8000, 16'h7FFF, -16'sd23040, 32'h80000000, 32'h7FFFFFFF,
                  32'h80000000, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000);
    send_directed(16'sd2880, 16'sd2880, 16'sd2880, 32'h7FFFFFFF, 32'h7FFFFFFF,
                  32'h7FFFFFFF, 0, 0, 0);
    send_directed(16'sd5761, -16'sd5761, 16'sd5759, 32'h80000000, 32'h80000000,
                  32'h80000000, 0, 0, 0);
    send_directed(16'sd34560, 16'sd1, 16'hFFFF, 32'h0, 32'h1, 32'hFFFFFFFF,
                  32'h10000, 32'h10000, 32'h10000);
    for (int n = 0; n < 250; n++) begin
      it.rot_x_deg = rand_angle();
      it.rot_y_deg = rand_angle();
      it.rot_z_deg = rand_angle();
      it.scale_x = rand_word();
      it.scale_y = rand_word();
      it.scale_z = rand_word();
      it.pos_x = $urandom;
      it.pos_y = $urandom;
      it.pos_z = $urandom;
      send_matrix(it, n < 200);
    end
    start <= 1'b0;
    while (pending_columns != 0) @(posedge clk);
    repeat (Steps + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
